[sv/ffea_pkg.sv]
`default_nettype none
package ffea_pkg;

  localparam int MAX_EXTENTS_DEF  = 64;
  localparam int ADDR_BITS_DEF    = 32;
  localparam int HEADER_BYTES_DEF = 8;

  localparam int LEN_W     = 32;
  localparam int FIELD_W   = 32;
  localparam int ADJ_W     = 8;
  localparam int ALIGN_W   = 8;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE = 1'd1;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EVAL  = 2'd1,
    S_APPLY = 2'd2
  } state_t;

  typedef struct packed {
    logic eval;
    logic apply;
    cmd_t cmd;
    logic full;
  } cell_ctl_t;

  typedef struct packed {
    logic prev_join;
    logic next_join;
    logic whole;
  } cell_dec_t;

  // Width of an address plus a length, as the extent end compares use it
  function automatic int sum_width(input int addr_bits);
    int w;
    begin
      w = (addr_bits > LEN_W) ? addr_bits : LEN_W;
      sum_width = (w + 1 > 64) ? 64 : w + 1;
    end
  endfunction

endpackage
`default_nettype wire

[sv/first_fit_extent_allocator_core.sv]
`default_nettype none
// First-fit extent allocator. Free extents sit in address order in a row of cells,
// one extent per cell. A command passes through two states: in the first every cell
// compares its extent against the request in parallel and registers the result, in
// the second a priority chain across the row picks the cell and the row shifts by one
// place for an insert or a removal. A new item is taken in the second state of the
// previous one, so the block can accept a new item before the last one is through;
// a result waiting in the output register holds the second state. The table is
// empty after reset; an init command loads the heap and a free can add extents.
module first_fit_extent_allocator_core #(
  parameter int MAX_EXTENTS  = ffea_pkg::MAX_EXTENTS_DEF,
  parameter int ADDR_BITS    = ffea_pkg::ADDR_BITS_DEF,
  parameter int HEADER_BYTES = ffea_pkg::HEADER_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ffea_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ffea_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       command,
  input  logic [ffea_pkg::FIELD_W-1:0]     request_size,
  input  logic [ffea_pkg::ALIGN_W-1:0]     alignment,
  input  logic [ffea_pkg::FIELD_W-1:0]     free_address,
  input  logic [ffea_pkg::FIELD_W-1:0]     free_size,
  input  logic [ffea_pkg::ADJ_W-1:0]       free_adjustment,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic [ffea_pkg::FIELD_W-1:0]     granted_address,
  output logic [ffea_pkg::FIELD_W-1:0]     granted_size,
  output logic [ffea_pkg::ADJ_W-1:0]       granted_adjustment,
  output logic [ffea_pkg::FIELD_W-1:0]     bytes_in_use,
  output logic [ffea_pkg::FIELD_W-1:0]     live_allocations
);
  import ffea_pkg::*;

  localparam int SUM_W = sum_width(ADDR_BITS);
  localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
  localparam int AW    = (ADDR_BITS > FIELD_W) ? ADDR_BITS : FIELD_W;

  state_t state, state_next;

  logic [ADDR_BITS-1:0] heap_base;
  logic [LEN_W-1:0]     heap_size;
  logic [CNT_W-1:0]     count, count_next;
  logic [FIELD_W-1:0]   usage, usage_next;
  logic [FIELD_W-1:0]   live, live_next;

  cmd_t               cmd_r;
  logic [LEN_W-1:0]   req_r;
  logic [ALIGN_W-1:0] align_r;
  logic [FIELD_W-1:0] faddr_r;
  logic [LEN_W-1:0]   fsize_r;
  logic [ADJ_W-1:0]   fadj_r;

  logic               accept;
  logic               fire;
  cell_ctl_t          ctl;
  cell_dec_t          dec;
  logic               any_hit;
  logic [ADDR_BITS-1:0] sel_start;
  logic [LEN_W-1:0]   sel_len;
  logic [ADJ_W-1:0]   sel_adj;

  logic [ALIGN_W-1:0] align_low;
  logic [ALIGN_W-1:0] align_mask;
  logic [ADDR_BITS-1:0] free_base;
  logic [ADDR_BITS-1:0] cell_base;
  logic [LEN_W-1:0]   cell_size;
  logic [SUM_W-1:0]   end_addr;
  logic [ADDR_BITS-1:0] grant_addr;

  status_t            status_c;
  logic [FIELD_W-1:0] ga_c, gs_c;
  logic [ADJ_W-1:0]   gj_c;

  // State machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    fire       = (state == S_APPLY) && !(out_valid && out_stall);
    // hold the input during reset
    in_stall   = rst || !((state == S_IDLE) || fire);
    accept     = in_valid && !in_stall;
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_EVAL;
      S_EVAL:  state_next = S_APPLY;
      S_APPLY: if (fire) state_next = accept ? S_EVAL : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= '0;
      heap_size <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_HEAP_BASE: heap_base <= ADDR_BITS'(cfg_data);
        CFG_HEAP_SIZE: heap_size <= LEN_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= cmd_t'(command);
      req_r   <= request_size;
      align_r <= alignment;
      faddr_r <= free_address;
      fsize_r <= free_size;
      fadj_r  <= free_adjustment;
    end
  end

  always_comb begin
    align_low  = align_r & (~align_r + ALIGN_W'(1));
    align_mask = (align_low == '0) ? '0 : align_low - ALIGN_W'(1);
    free_base  = ADDR_BITS'(AW'(faddr_r) - AW'(fadj_r));
    end_addr   = SUM_W'(free_base) + SUM_W'(fsize_r);
    cell_base  = (cmd_r == CMD_INIT) ? heap_base : free_base;
    cell_size  = (cmd_r == CMD_INIT) ? heap_size : fsize_r;
    ctl.eval   = state == S_EVAL;
    ctl.apply  = fire;
    ctl.cmd    = cmd_r;
    ctl.full   = count == CNT_W'(MAX_EXTENTS);
  end

  ffea_chain #(
    .MAX_EXTENTS (MAX_EXTENTS),
    .ADDR_BITS   (ADDR_BITS),
    .HEADER_BYTES(HEADER_BYTES),
    .SUM_W       (SUM_W),
    .CNT_W       (CNT_W)
  ) u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .count     (count),
    .req       (req_r),
    .align_mask(align_mask),
    .base      (cell_base),
    .end_addr  (end_addr),
    .size      (cell_size),
    .dec       (dec),
    .any_hit   (any_hit),
    .sel_start (sel_start),
    .sel_len   (sel_len),
    .sel_adj   (sel_adj)
  );

  // Result and totals for the command in its apply state
  always_comb begin
    status_c   = ST_OK;
    ga_c       = '0;
    gs_c       = '0;
    gj_c       = '0;
    usage_next = usage;
    live_next  = live;
    count_next = count;
    grant_addr = sel_start + ADDR_BITS'(sel_adj);
    case (cmd_r)
      CMD_ALLOC: begin
        if (any_hit) begin
          ga_c       = FIELD_W'(grant_addr);
          gs_c       = dec.whole ? sel_len : req_r + LEN_W'(sel_adj);
          gj_c       = sel_adj;
          usage_next = usage + gs_c;
          live_next  = live + FIELD_W'(1);
          if (dec.whole) count_next = count - CNT_W'(1);
        end else begin
          status_c = ST_NO_FIT;
        end
      end
      CMD_FREE: begin
        if (!dec.prev_join && !dec.next_join && ctl.full) begin
          status_c = ST_FULL;
        end else begin
          usage_next = usage - fsize_r;
          live_next  = live - FIELD_W'(1);
          if (dec.prev_join && dec.next_join) begin
            count_next = count - CNT_W'(1);
          end else if (!dec.prev_join && !dec.next_join) begin
            count_next = count + CNT_W'(1);
          end
        end
      end
      CMD_INIT: begin
        usage_next = '0;
        live_next  = '0;
        count_next = (heap_size != '0) ? CNT_W'(1) : CNT_W'(0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      usage     <= '0;
      live      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        count     <= count_next;
        usage     <= usage_next;
        live      <= live_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status             <= status_c;
      granted_address    <= ga_c;
      granted_size       <= gs_c;
      granted_adjustment <= gj_c;
      bytes_in_use       <= usage_next;
      live_allocations   <= live_next;
    end
  end

endmodule
`default_nettype wire

[sv/ffea_cell.sv]
`default_nettype none
module ffea_cell #(
  parameter int ADDR_BITS    = ffea_pkg::ADDR_BITS_DEF,
  parameter int HEADER_BYTES = ffea_pkg::HEADER_BYTES_DEF,
  parameter int SUM_W        = ffea_pkg::sum_width(ADDR_BITS)
) (
  input  logic                           clk,
  input  ffea_pkg::cell_ctl_t            ctl,
  input  ffea_pkg::cell_dec_t            dec,
  input  logic                           valid,
  input  logic [ffea_pkg::LEN_W-1:0]     req,
  input  logic [ffea_pkg::ALIGN_W-1:0]   align_mask,
  input  logic [ADDR_BITS-1:0]           base,
  input  logic [SUM_W-1:0]               end_addr,
  input  logic [ffea_pkg::LEN_W-1:0]     size,
  input  logic [ADDR_BITS-1:0]           up_start,
  input  logic [ffea_pkg::LEN_W-1:0]     up_len,
  input  logic [ADDR_BITS-1:0]           dn_start,
  input  logic [ffea_pkg::LEN_W-1:0]     dn_len,
  input  logic                           chain_in,
  input  logic                           next_after,
  output logic                           chain_out,
  output logic [ADDR_BITS-1:0]           start,
  output logic [ffea_pkg::LEN_W-1:0]     len,
  output logic [ffea_pkg::ADJ_W-1:0]     adj_r,
  output logic                           hit,
  output logic                           is_prev,
  output logic                           whole_r,
  output logic                           endj_r,
  output logic                           startj_r
);
  import ffea_pkg::*;

  logic                 flag_r;
  logic [ADJ_W-1:0]     gap;
  logic [ADJ_W-1:0]     adj_c;
  logic [LEN_W:0]       need;
  logic [LEN_W:0]       rem;
  logic                 fit;
  logic                 flag;
  logic [SUM_W-1:0]     start_x;
  logic [SUM_W-1:0]     tail_x;
  logic [ADDR_BITS-1:0] start_next;
  logic [LEN_W-1:0]     len_next;

  // Smallest adjustment of at least a header that aligns the extent start
  always_comb begin
    gap     = (ADJ_W'(0) - start[ADJ_W-1:0] - ADJ_W'(HEADER_BYTES)) & align_mask;
    adj_c   = ADJ_W'(HEADER_BYTES) + gap;
    need    = {1'b0, req} + (LEN_W+1)'(adj_c);
    rem     = {1'b0, len} - need;
    fit     = valid && ({1'b0, len} >= need);
    start_x = SUM_W'(start);
    tail_x  = start_x + SUM_W'(len);
    case (ctl.cmd)
      CMD_ALLOC: flag = fit;
      CMD_FREE:  flag = !valid || (start_x >= end_addr);
      CMD_INIT:  flag = 1'b1;
      default:   flag = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      flag_r   <= flag;
      whole_r  <= rem <= (LEN_W+1)'(HEADER_BYTES);
      endj_r   <= valid && (tail_x == SUM_W'(base));
      startj_r <= start_x == end_addr;
      adj_r    <= adj_c;
    end
  end

  assign chain_out = chain_in | flag_r;
  assign hit       = flag_r & ~chain_in;
  assign is_prev   = ~chain_out & next_after;

  always_comb begin
    start_next = start;
    len_next   = len;
    if (ctl.apply) begin
      case (ctl.cmd)
        CMD_ALLOC: begin
          if (hit && !dec.whole) begin
            start_next = start + ADDR_BITS'(req) + ADDR_BITS'(adj_r);
            len_next   = len - req - LEN_W'(adj_r);
          end else if ((hit || chain_in) && dec.whole) begin
            start_next = dn_start;
            len_next   = dn_len;
          end
        end
        CMD_FREE: begin
          if (dec.prev_join) begin
            if (is_prev) begin
              len_next = len + size + (dec.next_join ? dn_len : LEN_W'(0));
            end else if ((hit || chain_in) && dec.next_join) begin
              start_next = dn_start;
              len_next   = dn_len;
            end
          end else if (dec.next_join) begin
            if (hit) begin
              start_next = base;
              len_next   = len + size;
            end
          end else if (!ctl.full) begin
            if (hit) begin
              start_next = base;
              len_next   = size;
            end else if (chain_in) begin
              start_next = up_start;
              len_next   = up_len;
            end
          end
        end
        CMD_INIT: begin
          if (hit) begin
            start_next = base;
            len_next   = size;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    start <= start_next;
    len   <= len_next;
  end

endmodule
`default_nettype wire

[sv/ffea_chain.sv]
`default_nettype none
module ffea_chain #(
  parameter int MAX_EXTENTS  = ffea_pkg::MAX_EXTENTS_DEF,
  parameter int ADDR_BITS    = ffea_pkg::ADDR_BITS_DEF,
  parameter int HEADER_BYTES = ffea_pkg::HEADER_BYTES_DEF,
  parameter int SUM_W        = ffea_pkg::sum_width(ADDR_BITS),
  parameter int CNT_W        = $clog2(MAX_EXTENTS + 1)
) (
  input  logic                         clk,
  input  ffea_pkg::cell_ctl_t          ctl,
  input  logic [CNT_W-1:0]             count,
  input  logic [ffea_pkg::LEN_W-1:0]   req,
  input  logic [ffea_pkg::ALIGN_W-1:0] align_mask,
  input  logic [ADDR_BITS-1:0]         base,
  input  logic [SUM_W-1:0]             end_addr,
  input  logic [ffea_pkg::LEN_W-1:0]   size,
  output ffea_pkg::cell_dec_t          dec,
  output logic                         any_hit,
  output logic [ADDR_BITS-1:0]         sel_start,
  output logic [ffea_pkg::LEN_W-1:0]   sel_len,
  output logic [ffea_pkg::ADJ_W-1:0]   sel_adj
);
  import ffea_pkg::*;

  logic [ADDR_BITS-1:0] st     [MAX_EXTENTS];
  logic [LEN_W-1:0]     ln     [MAX_EXTENTS];
  logic [ADJ_W-1:0]     adj    [MAX_EXTENTS];
  logic [MAX_EXTENTS-1:0] valid, hit, is_prev, whole, endj, startj, after;

  for (genvar k = 0; k < MAX_EXTENTS; k++) begin : g_cell
    logic [ADDR_BITS-1:0] up_s, dn_s;
    logic [LEN_W-1:0]     up_l, dn_l;
    logic                 c_in, n_after;

    assign valid[k] = CNT_W'(k) < count;

    if (k == 0) begin : g_first
      assign up_s = '0;
      assign up_l = '0;
      assign c_in = 1'b0;
    end else begin : g_mid
      assign up_s = st[k-1];
      assign up_l = ln[k-1];
      assign c_in = after[k-1];
    end

    if (k == MAX_EXTENTS - 1) begin : g_last
      assign dn_s    = '0;
      assign dn_l    = '0;
      assign n_after = 1'b1;
    end else begin : g_inner
      assign dn_s    = st[k+1];
      assign dn_l    = ln[k+1];
      assign n_after = after[k+1];
    end

    ffea_cell #(
      .ADDR_BITS   (ADDR_BITS),
      .HEADER_BYTES(HEADER_BYTES),
      .SUM_W       (SUM_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .dec       (dec),
      .valid     (valid[k]),
      .req       (req),
      .align_mask(align_mask),
      .base      (base),
      .end_addr  (end_addr),
      .size      (size),
      .up_start  (up_s),
      .up_len    (up_l),
      .dn_start  (dn_s),
      .dn_len    (dn_l),
      .chain_in  (c_in),
      .next_after(n_after),
      .chain_out (after[k]),
      .start     (st[k]),
      .len       (ln[k]),
      .adj_r     (adj[k]),
      .hit       (hit[k]),
      .is_prev   (is_prev[k]),
      .whole_r   (whole[k]),
      .endj_r    (endj[k]),
      .startj_r  (startj[k])
    );
  end

  // At most one cell hits, so an OR of the masked values selects it
  always_comb begin
    dec       = '0;
    sel_start = '0;
    sel_len   = '0;
    sel_adj   = '0;
    for (int k = 0; k < MAX_EXTENTS; k++) begin
      dec.whole     = dec.whole     | (hit[k] & whole[k]);
      dec.next_join = dec.next_join | (hit[k] & valid[k] & startj[k]);
      dec.prev_join = dec.prev_join | (is_prev[k] & endj[k]);
      sel_start     = sel_start | (st[k]  & {ADDR_BITS{hit[k]}});
      sel_len       = sel_len   | (ln[k]  & {LEN_W{hit[k]}});
      sel_adj       = sel_adj   | (adj[k] & {ADJ_W{hit[k]}});
    end
  end

  assign any_hit = after[MAX_EXTENTS-1];

endmodule
`default_nettype wire

[sim/first_fit_extent_allocator_core_test.sv]
`default_nettype none
module first_fit_extent_allocator_core_test;
  import ffea_pkg::*;

  localparam int  NUM_CELLS = MAX_EXTENTS_DEF;
  localparam int  HDR       = HEADER_BYTES_DEF;
  localparam bit [63:0] M32 = 64'hFFFF_FFFF;
  localparam int  WATCHDOG  = 5000;

  typedef struct {
    status_t   st;
    bit [31:0] addr;
    bit [31:0] size;
    bit [7:0]  adj;
    bit [31:0] used;
    bit [31:0] live;
  } grant_res_t;

  typedef struct {
    cmd_t       cmd;
    bit [31:0]  req;
    bit [7:0]   align;
    bit [31:0]  faddr;
    bit [31:0]  fsize;
    bit [7:0]   fadj;
    bit         typed;
    grant_res_t res;
  } stim_row_t;

  typedef struct {
    bit [31:0] addr;
    bit [31:0] size;
    bit [7:0]  adj;
  } block_t;

  logic        clk, rst;
  logic        cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic [1:0]  command;
  logic [31:0] request_size, free_address, free_size;
  logic [7:0]  alignment, free_adjustment;
  logic [1:0]  status;
  logic [31:0] granted_address, granted_size, bytes_in_use, live_allocations;
  logic [7:0]  granted_adjustment;

  first_fit_extent_allocator_core i_dut (.*);

  // shadow of the allocator state
  bit [63:0] ext_start [NUM_CELLS];
  bit [63:0] ext_len   [NUM_CELLS];
  int        ext_n;
  bit [31:0] usage_sum, live_sum;
  bit [31:0] heap_base_q, heap_size_q;

  grant_res_t pending_grants[$];
  block_t     live_blocks[$];
  bit         quiet;
  bit         failed;
  int         idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void drop_cell(int i);
    for (int k = i; k + 1 < ext_n; k++) begin
      ext_start[k] = ext_start[k+1];
      ext_len[k]   = ext_len[k+1];
    end
    ext_n--;
  endfunction

  function automatic grant_res_t allocator_step(stim_row_t s);
    grant_res_t r;
    bit [63:0] al, st, ln, adj, need, base, fin;
    bit prev_join, next_join;
    int i;
    r = '{ST_OK, 0, 0, 0, 0, 0};
    case (s.cmd)
      CMD_ALLOC: begin
        al = {56'd0, s.align & (~s.align + 8'd1)};
        if (al == 0) al = 1;
        r.st = ST_NO_FIT;
        for (i = 0; i < ext_n; i++) begin
          st = ext_start[i];
          ln = ext_len[i];
          adj = (al - (st & (al - 1))) & (al - 1);
          if (adj < HDR) adj += al * ((HDR - adj + al - 1) / al);
          need = {32'd0, s.req} + adj;
          if (ln < need) continue;
          if (ln - need <= HDR) begin
            need = ln;
            drop_cell(i);
          end else begin
            ext_start[i] = (st + need) & M32;
            ext_len[i]   = ln - need;
          end
          r = '{ST_OK, 32'((st + adj) & M32), 32'(need), 8'(adj), 0, 0};
          usage_sum += 32'(need);
          live_sum  += 1;
          break;
        end
      end
      CMD_FREE: begin
        base = ({32'd0, s.faddr} - {56'd0, s.fadj}) & M32;
        fin  = base + {32'd0, s.fsize};
        i = 0;
        while (i < ext_n && ext_start[i] < fin) i++;
        prev_join = i > 0 && ext_start[i-1] + ext_len[i-1] == base;
        next_join = i < ext_n && ext_start[i] == fin;
        if (prev_join) begin
          ext_len[i-1] = (ext_len[i-1] + s.fsize) & M32;
          if (next_join) begin
            ext_len[i-1] = (ext_len[i-1] + ext_len[i]) & M32;
            drop_cell(i);
          end
        end else if (next_join) begin
          ext_start[i] = base;
          ext_len[i]   = (ext_len[i] + s.fsize) & M32;
        end else if (ext_n >= NUM_CELLS) begin
          r.st = ST_FULL;
        end else begin
          for (int k = ext_n; k > i; k--) begin
            ext_start[k] = ext_start[k-1];
            ext_len[k]   = ext_len[k-1];
          end
          ext_start[i] = base;
          ext_len[i]   = {32'd0, s.fsize};
          ext_n++;
        end
        if (r.st == ST_OK) begin
          usage_sum -= s.fsize;
          live_sum  -= 1;
        end
      end
      CMD_INIT: begin
        ext_n = 0;
        if (heap_size_q != 0) begin
          ext_start[0] = {32'd0, heap_base_q};
          ext_len[0]   = {32'd0, heap_size_q};
          ext_n = 1;
        end
        usage_sum = 0;
        live_sum  = 0;
      end
      default: ;
    endcase
    r.used = usage_sum;
    r.live = live_sum;
    return r;
  endfunction

  // present one command, wait for its transfer, then record the expected grant
  task automatic send(stim_row_t s);
    grant_res_t r;
    if (!quiet && $urandom_range(99) < 27) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    command         = s.cmd;
    request_size    = s.req;
    alignment       = s.align;
    free_address    = s.faddr;
    free_size       = s.fsize;
    free_adjustment = s.fadj;
    in_valid        = 1'b1;
    do @(posedge clk); while (in_stall);
    r = allocator_step(s);
    pending_grants.push_back(s.typed ? s.res : r);
    if (s.cmd == CMD_ALLOC && r.st == ST_OK)
      live_blocks.push_back('{r.addr, r.size, r.adj});
    if (s.cmd == CMD_INIT) live_blocks.delete();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    wait (pending_grants.size() == 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == CFG_HEAP_BASE) heap_base_q = val;
    else heap_size_q = val;
  endtask

  function automatic stim_row_t plain(cmd_t c);
    stim_row_t s;
    s = '{c, 0, 8'd1, 0, 0, 0, 1'b0, '{ST_OK, 0, 0, 0, 0, 0}};
    return s;
  endfunction

  task automatic random_cmd();
    stim_row_t s;
    int pick, j;
    block_t b;
    pick = $urandom_range(99);
    if (pick < 38 && live_blocks.size() > 0) begin
      j = $urandom_range(live_blocks.size() - 1);
      b = live_blocks[j];
      live_blocks.delete(j);
      s = plain(CMD_FREE);
      s.faddr = b.addr;
      s.fsize = b.size;
      s.fadj  = b.adj;
    end else if (pick < 45) begin
      s = plain(CMD_FREE);
      s.faddr = $urandom();
      s.fsize = $urandom_range(3) == 0 ? $urandom() : $urandom_range(0, 512);
      s.fadj  = $urandom_range(255);
    end else if (pick < 48) begin
      s = plain(CMD_INIT);
    end else if (pick < 51) begin
      s = plain(CMD_NOP);
      s.req = $urandom();
    end else begin
      s = plain(CMD_ALLOC);
      j = $urandom_range(19);
      s.req   = j == 0 ? $urandom() : j < 3 ? $urandom_range(0, 32'hFFFF) : $urandom_range(0, 300);
      s.align = $urandom_range(9) == 0 ? 8'($urandom_range(1, 255)) : 8'(1 << $urandom_range(7));
    end
    send(s);
  endtask

  // carve many small blocks, then release every other one to fill the table
  task automatic fragment(int count);
    stim_row_t s;
    block_t kept[$];
    send(plain(CMD_INIT));
    for (int n = 0; n < count; n++) begin
      s = plain(CMD_ALLOC);
      s.req   = $urandom_range(1, 40);
      s.align = 8'(1 << $urandom_range(3));
      send(s);
    end
    kept = live_blocks;
    for (int n = 0; n < kept.size(); n += 2) begin
      s = plain(CMD_FREE);
      s.faddr = kept[n].addr;
      s.fsize = kept[n].size;
      s.fadj  = kept[n].adj;
      send(s);
    end
  endtask

  stim_row_t dir_tab[18];

  initial begin
    dir_tab = '{
      '{CMD_ALLOC, 16, 1, 0, 0, 0, 1, '{ST_NO_FIT, 0, 0, 0, 0, 0}},
      '{CMD_NOP, '1, '1, '1, '1, '1, 1, '{ST_OK, 0, 0, 0, 0, 0}},
      '{CMD_INIT, 0, 1, 0, 0, 0, 1, '{ST_OK, 0, 0, 0, 0, 0}},
      '{CMD_ALLOC, 16, 1, 0, 0, 0, 1, '{ST_OK, 32'h1008, 24, 8, 24, 1}},
      '{CMD_ALLOC, 0, 128, 0, 0, 0, 0, '{ST_OK, 0, 0, 0, 0, 0}},
      '{CMD_ALLOC, '1, 4, 0, 0, 0, 0, '{ST_OK, 0, 0, 0, 0, 0}},
      '{CMD_ALLOC, 5, 3, 0, 0, 0, 0, '{ST_OK, 0, 0, 0, 0, 0}},
      '{CMD_ALLOC, 7, 255, 0, 0, 0, 0, '{ST_OK, 0, 0, 0, 0, 0}},
      '{CMD_ALLOC, 33, 6, 0, 0, 0, 0, '{ST_OK, 0, 0, 0, 0, 0}},
      '{CMD_FREE, 0, 1, 32'h1008, 24, 8, 0, '{ST_OK, 0, 0, 0, 0, 0}},
      '{CMD_FREE, 0, 1, 32'h1080, 104, 104, 0, '{ST_OK, 0, 0, 0, 0, 0}},
      '{CMD_FREE, 0, 1, '1, '1, '1, 0, '{ST_OK, 0, 0, 0, 0, 0}},
      '{CMD_INIT, 0, 1, 0, 0, 0, 1, '{ST_OK, 0, 0, 0, 0, 0}},
      '{CMD_ALLOC, 32'hFF0, 1, 0, 0, 0, 1, '{ST_OK, 32'h1008, 32'h1000, 8, 32'h1000, 1}},
      '{CMD_ALLOC, 1, 1, 0, 0, 0, 1, '{ST_NO_FIT, 0, 0, 0, 32'h1000, 1}},
      '{CMD_FREE, 0, 1, 32'h1008, 32'h1000, 8, 1, '{ST_OK, 0, 0, 0, 0, 0}},
      '{CMD_ALLOC, 32'h8000_0000, 128, 0, 0, 0, 0, '{ST_OK, 0, 0, 0, 0, 0}},
      '{CMD_INIT, 0, 1, 0, 0, 0, 1, '{ST_OK, 0, 0, 0, 0, 0}}
    };
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    command = '0;
    request_size = '0;
    alignment = 8'd1;
    free_address = '0;
    free_size = '0;
    free_adjustment = '0;
    quiet = 1'b0;
    failed = 1'b0;
    ext_n = 0;
    usage_sum = 0;
    live_sum = 0;
    heap_base_q = 0;
    heap_size_q = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    write_reg(CFG_HEAP_BASE, 32'h1000);
    write_reg(CFG_HEAP_SIZE, 32'h1000);
    foreach (dir_tab[k]) send(dir_tab[k]);
    drain();

    write_reg(CFG_HEAP_SIZE, 32'h10000);
    fragment(150);
    for (int n = 0; n < 120; n++) random_cmd();
    drain();
    send(plain(CMD_INIT));
    for (int n = 0; n < 120; n++) random_cmd();
    drain();

    // top of the address space with the largest heap, no idling on either side
    quiet = 1'b1;
    write_reg(CFG_HEAP_BASE, 32'hFFFF_FFF0);
    write_reg(CFG_HEAP_SIZE, 32'hFFFF_FFFF);
    send(plain(CMD_INIT));
    for (int n = 0; n < 150; n++) random_cmd();
    drain();
    quiet = 1'b0;

    write_reg(CFG_HEAP_BASE, 32'h0);
    write_reg(CFG_HEAP_SIZE, 32'h0);
    send(plain(CMD_INIT));
    for (int n = 0; n < 30; n++) random_cmd();
    drain();

    write_reg(CFG_HEAP_BASE, $urandom());
    write_reg(CFG_HEAP_SIZE, 32'h200);
    send(plain(CMD_INIT));
    for (int n = 0; n < 150; n++) random_cmd();
    drain();

    if (!failed) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  always @(negedge clk) out_stall <= !quiet && $urandom_range(99) < 27;

  always @(posedge clk) begin
    grant_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_grants.size() == 0) begin
        $error("grant transfer with nothing expected");
        failed = 1'b1;
      end else begin
        e = pending_grants.pop_front();
        if (status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, status);
          failed = 1'b1;
        end
        if (granted_address !== e.addr) begin
          $error("granted_address: expected %h, got %h", e.addr, granted_address);
          failed = 1'b1;
        end
        if (granted_size !== e.size) begin
          $error("granted_size: expected %h, got %h", e.size, granted_size);
          failed = 1'b1;
        end
        if (granted_adjustment !== e.adj) begin
          $error("granted_adjustment: expected %h, got %h", e.adj, granted_adjustment);
          failed = 1'b1;
        end
        if (bytes_in_use !== e.used) begin
          $error("bytes_in_use: expected %h, got %h", e.used, bytes_in_use);
          failed = 1'b1;
        end
        if (live_allocations !== e.live) begin
          $error("live_allocations: expected %h, got %h", e.live, live_allocations);
          failed = 1'b1;
        end
      end
    end
  end

  // stop a hung run: count cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule
`default_nettype wire

[sim.f]
sv/ffea_pkg.sv
sv/ffea_cell.sv
sv/ffea_chain.sv
sv/first_fit_extent_allocator_core.sv
sim/first_fit_extent_allocator_core_test.sv
